// ===== hw/rtl/tsr_pkg.sv =====
// Shared constants and lookup functions for the tilt to servo ramp block.
`timescale 1ns / 1ps
`default_nettype none
package tsr_pkg;

  localparam int ACCEL_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int Z_W              = 17;
  localparam int THR_W            = 15;
  localparam logic [THR_W-1:0] THR_RESET = 15'd8192;

  // Arctangent of two to the minus index, in degrees at Q8.8.
  function automatic logic signed [Z_W-1:0] tsr_atan(input logic [4:0] idx);
    logic signed [Z_W-1:0] v;
    begin
      unique case (idx)
        5'd0:    v = 17'sd11520;
        5'd1:    v = 17'sd6801;
        5'd2:    v = 17'sd3593;
        5'd3:    v = 17'sd1824;
        5'd4:    v = 17'sd916;
        5'd5:    v = 17'sd458;
        5'd6:    v = 17'sd229;
        5'd7:    v = 17'sd115;
        5'd8:    v = 17'sd57;
        5'd9:    v = 17'sd29;
        5'd10:   v = 17'sd14;
        5'd11:   v = 17'sd7;
        5'd12:   v = 17'sd4;
        5'd13:   v = 17'sd2;
        5'd14:   v = 17'sd1;
        default: v = 17'sd0;
      endcase
      return v;
    end
  endfunction

  // Servo angle for each range of the quantized tilt.
  function automatic logic [7:0] tsr_servo(input logic [5:0] rng);
    logic [7:0] v;
    begin
      unique case (rng)
        6'd0:    v = 8'd0;
        6'd1:    v = 8'd10;
        6'd2:    v = 8'd15;
        6'd3:    v = 8'd20;
        6'd4:    v = 8'd25;
        6'd5:    v = 8'd30;
        6'd6:    v = 8'd35;
        6'd7:    v = 8'd40;
        6'd8:    v = 8'd45;
        6'd9:    v = 8'd50;
        6'd10:   v = 8'd55;
        6'd11:   v = 8'd65;
        6'd12:   v = 8'd75;
        6'd13:   v = 8'd80;
        6'd14:   v = 8'd85;
        6'd15:   v = 8'd90;
        6'd16:   v = 8'd95;
        6'd17:   v = 8'd100;
        6'd18:   v = 8'd105;
        6'd19:   v = 8'd110;
        6'd20:   v = 8'd115;
        6'd21:   v = 8'd120;
        6'd22:   v = 8'd125;
        6'd23:   v = 8'd130;
        6'd24:   v = 8'd135;
        6'd25:   v = 8'd140;
        6'd26:   v = 8'd145;
        6'd27:   v = 8'd150;
        6'd28:   v = 8'd155;
        6'd29:   v = 8'd160;
        6'd30:   v = 8'd165;
        6'd31:   v = 8'd170;
        6'd32:   v = 8'd175;
        default: v = 8'd180;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tsr_isqrt.sv =====
// Bit-serial integer square root, one root bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tsr_isqrt #(
  parameter int RootW = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [2*RootW-1:0]   radicand,
  output logic                      done,
  output logic [RootW-1:0]          root
);
  localparam int CntW = $clog2(RootW);

  logic                 busy;
  logic [CntW-1:0]      cnt;
  logic [2*RootW-1:0]   rad;
  logic [RootW+1:0]     rem;
  logic [RootW+1:0]     rem_sh;
  logic [RootW+1:0]     trial;
  logic                 fits;

  assign rem_sh = {rem[RootW-1:0], rad[2*RootW-1:2*RootW-2]};
  assign trial  = {root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(RootW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[2*RootW-3:0], 2'b00};
      if (fits) begin
        rem  <= rem_sh - trial;
        root <= {root[RootW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[RootW-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tsr_cordic.sv =====
// Iterative CORDIC in vectoring mode, one rotation per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tsr_cordic #(
  parameter int DataW = 27,
  parameter int Steps = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic signed [DataW-1:0]     x0,
  input  wire logic signed [DataW-1:0]     y0,
  output logic                             done,
  output logic signed [tsr_pkg::Z_W-1:0]   angle
);
  import tsr_pkg::*;

  localparam int IdxW = $clog2(Steps);

  logic                     busy;
  logic [IdxW-1:0]          idx;
  logic signed [DataW-1:0]  cx;
  logic signed [DataW-1:0]  cy;
  logic signed [DataW-1:0]  dx;
  logic signed [DataW-1:0]  dy;
  logic signed [Z_W-1:0]    step_ang;

  assign dx       = cy >>> idx;
  assign dy       = cx >>> idx;
  assign step_ang = tsr_atan(5'(idx));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (busy) begin
        idx <= idx + 1'b1;
        if (idx == IdxW'(Steps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cx    <= x0;
      cy    <= y0;
      angle <= '0;
    end else if (busy) begin
      if (!cy[DataW-1]) begin
        cx    <= cx + dx;
        cy    <= cy - dy;
        angle <= angle + step_ang;
      end else begin
        cx    <= cx - dx;
        cy    <= cy + dy;
        angle <= angle - step_ang;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tilt_to_servo_ramp.sv =====
// Top level: accelerometer tilt to a quantized servo angle with a one-degree ramp.
`timescale 1ns / 1ps
`default_nettype none
// A beat with cmd 0 is an accelerometer sample and always yields one result beat carrying
// its quantized servo angle; a beat with cmd 1 is a tick that yields a ramp step while a
// ramp is active and nothing otherwise. One beat is worked on at a time. A tick goes
// from idle straight to the output state. A sample passes through the bit-serial square
// root, one root bit per cycle, and then through the CORDIC unit, one rotation per cycle.
// The threshold register may be written at any time on its own channel.
module tilt_to_servo_ramp #(
  parameter int ACCEL_BITS   = tsr_pkg::ACCEL_BITS_DEF,
  parameter int CORDIC_STEPS = tsr_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tsr_pkg::THR_W-1:0]      cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           cmd,
  input  wire logic signed [ACCEL_BITS-1:0]   accel_x,
  input  wire logic signed [ACCEL_BITS-1:0]   accel_y,
  input  wire logic signed [ACCEL_BITS-1:0]   accel_z,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [7:0]                          angle_deg,
  output logic [11:0]                         pwm_level,
  output logic                                pwm_valid,
  output logic                                ramp_done,
  output logic                                sample_dropped
);
  import tsr_pkg::*;

  localparam int RootW = ACCEL_BITS + 8;
  localparam int DataW = ACCEL_BITS + 11;
  localparam int CmpW  = (ACCEL_BITS + 1 > THR_W) ? ACCEL_BITS + 1 : THR_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SQ    = 7'b0000010,
    S_SUM   = 7'b0000100,
    S_ROOT  = 7'b0001000,
    S_ROT   = 7'b0010000,
    S_QUANT = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [THR_W-1:0]               y_threshold;
  logic [7:0]                     position_deg;
  logic                           position_known;
  logic [7:0]                     target_deg;
  logic                           ramp_active;

  logic                           cmd_r;
  logic signed [ACCEL_BITS-1:0]   xr;
  logic signed [ACCEL_BITS-1:0]   yr;
  logic signed [ACCEL_BITS-1:0]   zr;
  logic signed [2*ACCEL_BITS-1:0] yy;
  logic signed [2*ACCEL_BITS-1:0] zz;
  logic [2*ACCEL_BITS-1:0]        sumsq;
  logic signed [Z_W-1:0]          z_ang;
  logic [7:0]                     q;

  logic                           sqrt_start;
  logic                           sqrt_done;
  logic [RootW-1:0]               root;
  logic                           cordic_start;
  logic                           cordic_done;
  logic signed [Z_W-1:0]          cordic_ang;
  logic signed [DataW-1:0]        cx0;
  logic signed [DataW-1:0]        cy0;

  logic signed [Z_W:0]            ang_raw;
  logic [15:0]                    ang_clip;
  logic [21:0]                    rng_prod;
  logic [5:0]                     rng;

  logic signed [ACCEL_BITS:0]     yext;
  logic [ACCEL_BITS:0]            ay;
  logic                           y_large;
  logic [7:0]                     pos_step;
  logic [28:0]                    lvl_prod;
  logic [11:0]                    lvl;
  logic                           out_free;
  logic                           all_zero;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;

  assign sumsq        = (2*ACCEL_BITS)'($unsigned(yy)) + (2*ACCEL_BITS)'($unsigned(zz));
  assign sqrt_start   = (state == S_SUM);
  assign cordic_start = (state == S_ROOT) && sqrt_done;
  assign cx0          = DataW'(root);
  assign cy0          = {{3{xr[ACCEL_BITS-1]}}, xr, 8'b0};
  assign all_zero     = (xr == '0) && (yr == '0) && (zr == '0);

  tsr_isqrt #(.RootW(RootW)) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand ({sumsq, 16'b0}),
    .done     (sqrt_done),
    .root     (root)
  );

  tsr_cordic #(.DataW(DataW), .Steps(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .x0    (cx0),
    .y0    (cy0),
    .done  (cordic_done),
    .angle (cordic_ang)
  );

  assign ang_raw  = (Z_W+1)'(23040) + (Z_W+1)'(z_ang);
  assign ang_clip = ang_raw[Z_W] ? 16'd0 :
                    (ang_raw > (Z_W+1)'(46080)) ? 16'd46080 : ang_raw[15:0];
  assign rng_prod = 22'(ang_clip[15:5]) * 22'd1457;
  assign rng      = rng_prod[21:16];

  assign yext    = {yr[ACCEL_BITS-1], yr};
  assign ay      = yext[ACCEL_BITS] ? (ACCEL_BITS+1)'(-yext) : (ACCEL_BITS+1)'(yext);
  assign y_large = CmpW'(ay) > CmpW'(y_threshold);

  always_comb begin
    if (target_deg > position_deg) begin
      pos_step = position_deg + 8'd1;
    end else if (target_deg < position_deg) begin
      pos_step = position_deg - 8'd1;
    end else begin
      pos_step = position_deg;
    end
  end

  assign lvl_prod = 29'(pos_step) * 29'd1456400;
  assign lvl      = 12'd500 + lvl_prod[28:17];

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (!cmd) begin
            state_next = S_SQ;
          end else if (ramp_active) begin
            state_next = S_OUT;
          end
        end
      end
      S_SQ:    state_next = S_SUM;
      S_SUM:   state_next = S_ROOT;
      S_ROOT:  if (sqrt_done) state_next = S_ROT;
      S_ROT:   if (cordic_done) state_next = S_QUANT;
      S_QUANT: state_next = S_OUT;
      S_OUT:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      y_threshold    <= THR_RESET;
      position_deg   <= 8'd0;
      position_known <= 1'b0;
      target_deg     <= 8'd0;
      ramp_active    <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        y_threshold <= cfg_data;
      end
      if ((state == S_OUT) && out_free) begin
        out_valid <= 1'b1;
        if (!cmd_r) begin
          if (ramp_active) begin
          end else if (!position_known || y_large) begin
            position_known <= 1'b1;
            position_deg   <= q;
            target_deg     <= q;
          end else if (q != position_deg) begin
            target_deg  <= q;
            ramp_active <= 1'b1;
          end
        end else begin
          position_deg <= pos_step;
          if (pos_step == target_deg) begin
            ramp_active <= 1'b0;
          end
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= cmd;
      xr    <= accel_x;
      yr    <= accel_y;
      zr    <= accel_z;
    end
    if (state == S_SQ) begin
      yy <= yr * yr;
      zz <= zr * zr;
    end
    if ((state == S_ROT) && cordic_done) begin
      z_ang <= all_zero ? '0 : cordic_ang;
    end
    if (state == S_QUANT) begin
      q <= tsr_servo(rng);
    end
    if ((state == S_OUT) && out_free) begin
      if (!cmd_r) begin
        angle_deg      <= q;
        pwm_level      <= 12'd0;
        pwm_valid      <= 1'b0;
        ramp_done      <= 1'b0;
        sample_dropped <= ramp_active;
      end else begin
        angle_deg      <= pos_step;
        pwm_level      <= lvl;
        pwm_valid      <= 1'b1;
        ramp_done      <= (pos_step == target_deg);
        sample_dropped <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_ramp_known: assert property (@(posedge clk) disable iff (rst)
    ramp_active |-> position_known)
    else $error("ramp active without a known position");

  a_ramp_moves: assert property (@(posedge clk) disable iff (rst)
    ramp_active |-> (target_deg != position_deg))
    else $error("ramp active with position at target");

  a_step_not_drop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pwm_valid) |-> !sample_dropped)
    else $error("ramp step flagged as dropped sample");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (angle_deg <= 8'd180))
    else $error("angle out of range");
`endif

endmodule
`default_nettype wire
